// ----- rtl/core/tsk_pkg.sv -----
// ----------------------------------------------------------------------------
// Top-k selector package
// Shared widths, constants and types for the streaming top-k selector.
// ----------------------------------------------------------------------------
package tsk_pkg;

  // Field widths of the stream payloads.
  localparam int unsigned KeyW    = 32;
  localparam int unsigned OutPosW = 17;
  localparam int unsigned KCountW = 5;

  // Row length limit; positions saturate at RowMax - 1.
  localparam longint unsigned RowMax = 65536;
  localparam int unsigned     PosW   = 16;

  // Default number of kept entries.
  localparam int unsigned KMaxDefault = 16;

  // Depth of the queue between front and back.
  localparam int unsigned FifoDepth = 2;

  // Padding result fields.
  localparam logic signed [KeyW-1:0]    PadValue    = '0;
  localparam logic signed [OutPosW-1:0] PadPosition = '1;

  // One numbered key on its way from front to back.
  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [PosW-1:0]        pos;
    logic                   last;
  } tsk_item_t;

  // Back-end sequencer states.
  typedef enum logic {
    ST_INSERT,
    ST_EMIT
  } tsk_state_e;

endpackage

// ----- rtl/core/tsk_front.sv -----
// ----------------------------------------------------------------------------
// Top-k selector front end
// Accepts input beats, numbers each key by its row position and pushes it
// into the queue toward the back end.
// ----------------------------------------------------------------------------
module tsk_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [tsk_pkg::KeyW-1:0] in_key_i,
  input  logic                            in_last_i,
  output logic                            push_valid_o,
  input  logic                            push_ready_i,
  output tsk_pkg::tsk_item_t              push_item_o
);

  localparam logic [tsk_pkg::PosW-1:0] PosLimit = tsk_pkg::PosW'(tsk_pkg::RowMax - 1);

  logic [tsk_pkg::PosW-1:0] pos_q, pos_d;
  logic                     accept;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;

  // The accepted beat carries the current position.
  always_comb begin
    push_item_o.key  = in_key_i;
    push_item_o.pos  = pos_q;
    push_item_o.last = in_last_i;
  end

  // Position counter: restarts after the row's last beat, saturates on long rows.
  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (in_last_i) begin
        pos_d = '0;
      end else if (pos_q != PosLimit) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ----- rtl/core/tsk_fifo.sv -----
// ----------------------------------------------------------------------------
// Top-k selector queue
// Short first-in first-out queue that decouples the front end from the
// insertion array.
// ----------------------------------------------------------------------------
module tsk_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  tsk_pkg::tsk_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output tsk_pkg::tsk_item_t pop_item_o
);

  localparam int unsigned Depth = tsk_pkg::FifoDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  tsk_pkg::tsk_item_t mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill-level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

`ifndef SYNTH
  // The fill level never exceeds the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(Depth))
    else $error("tsk_fifo: fill level above depth");

  // A push alone raises the fill level by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("tsk_fifo: fill level did not follow a push");

  // Nothing is popped from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (cnt_q == '0) |-> !pop)
    else $error("tsk_fifo: pop from empty queue");
`endif

endmodule

// ----- rtl/core/tsk_back.sv -----
// ----------------------------------------------------------------------------
// Top-k selector back end
// Sorted insertion array of the kept keys and the result sequencer that
// drains it through an output register after each row.
// ----------------------------------------------------------------------------
module tsk_back #(
  parameter int unsigned K_MAX = tsk_pkg::KMaxDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [tsk_pkg::KCountW-1:0]        k_count_i,
  input  logic                               pop_valid_i,
  output logic                               pop_ready_o,
  input  tsk_pkg::tsk_item_t                 pop_item_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [tsk_pkg::KeyW-1:0]    out_value_o,
  output logic signed [tsk_pkg::OutPosW-1:0] out_position_o,
  output logic                               out_last_o
);

  localparam int unsigned CntW = $clog2(K_MAX + 1);
  localparam int unsigned IdxW = (K_MAX > 1) ? $clog2(K_MAX) : 1;

  // Kept entries, sorted by descending key, ties by ascending position.
  logic signed [tsk_pkg::KeyW-1:0] keys_q [K_MAX];
  logic [tsk_pkg::PosW-1:0]        poss_q [K_MAX];
  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic [CntW-1:0]                 k_eff, cnt_eff;
  logic [K_MAX-1:0]                ge;
  logic [K_MAX:0]                  ge_prev;

  tsk_pkg::tsk_state_e state_q, state_d;
  logic [CntW-1:0]     em_q, em_d;
  logic                do_insert, em_load, em_done;

  logic                               out_valid_q, out_valid_d;
  logic signed [tsk_pkg::KeyW-1:0]    out_value_q;
  logic signed [tsk_pkg::OutPosW-1:0] out_position_q;
  logic                               out_last_q;

  // Effective k: zero acts as one, large values clamp to the array size.
  always_comb begin
    if (k_count_i == '0) begin
      k_eff = CntW'(1);
    end else if (32'(k_count_i) > K_MAX) begin
      k_eff = CntW'(K_MAX);
    end else begin
      k_eff = CntW'(k_count_i);
    end
    cnt_eff = (cnt_q < k_eff) ? cnt_q : k_eff;
  end

  // Parallel compare: a kept entry stays ahead when its key is not smaller.
  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      ge[i] = (CntW'(i) < cnt_eff) && (keys_q[i] >= pop_item_i.key);
    end
    ge_prev = {ge, 1'b1};
  end

  assign pop_ready_o = (state_q == tsk_pkg::ST_INSERT);
  assign do_insert   = pop_valid_i && pop_ready_o;

  // Insertion: entries ahead keep, the first free slot takes the key, the
  // rest shift down one place. A key that ties the last entry of a full
  // list lands past k and is never read.
  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      for (int i = 0; i < K_MAX; i++) begin
        if (!ge[i]) begin
          if (ge_prev[i]) begin
            keys_q[i] <= pop_item_i.key;
            poss_q[i] <= pop_item_i.pos;
          end else begin
            keys_q[i] <= keys_q[(i > 0) ? i - 1 : 0];
            poss_q[i] <= poss_q[(i > 0) ? i - 1 : 0];
          end
        end
      end
    end
  end

  // Result sequencer.
  assign em_load = (state_q == tsk_pkg::ST_EMIT) && (!out_valid_q || out_ready_i);
  assign em_done = (em_q + 1'b1 == k_eff);

  always_comb begin
    state_d     = state_q;
    em_d        = em_q;
    // A smaller k cuts the kept count for good, even if k grows again later.
    cnt_d       = cnt_eff;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      tsk_pkg::ST_INSERT: begin
        if (do_insert) begin
          cnt_d = (cnt_eff < k_eff) ? cnt_eff + 1'b1 : k_eff;
          if (pop_item_i.last) begin
            state_d = tsk_pkg::ST_EMIT;
            em_d    = '0;
          end
        end
      end
      tsk_pkg::ST_EMIT: begin
        if (em_load) begin
          out_valid_d = 1'b1;
          if (em_done) begin
            state_d = tsk_pkg::ST_INSERT;
            cnt_d   = '0;
          end else begin
            em_d = em_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = tsk_pkg::ST_INSERT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsk_pkg::ST_INSERT;
      em_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      em_q        <= em_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register: a kept entry or a padding slot.
  always_ff @(posedge clk_i) begin
    if (em_load) begin
      if (em_q < cnt_eff) begin
        out_value_q    <= keys_q[em_q[IdxW-1:0]];
        out_position_q <= signed'({1'b0, poss_q[em_q[IdxW-1:0]]});
      end else begin
        out_value_q    <= tsk_pkg::PadValue;
        out_position_q <= tsk_pkg::PadPosition;
      end
      out_last_q <= em_done;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_value_o    = out_value_q;
  assign out_position_o = out_position_q;
  assign out_last_o     = out_last_q;

`ifndef SYNTH
  // The kept count never exceeds the array size.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(K_MAX))
    else $error("tsk_back: kept count above array size");

  // While results drain, the result index stays below k.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsk_pkg::ST_EMIT) |-> (em_q < k_eff))
    else $error("tsk_back: result index out of range");

  // The first two valid entries are in descending order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_eff >= CntW'(2)) |-> (keys_q[0] >= keys_q[(K_MAX > 1) ? 1 : 0]))
    else $error("tsk_back: kept list out of order");

  // The final result of a row returns the sequencer to insertion.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (em_load && em_done) |=> (state_q == tsk_pkg::ST_INSERT && cnt_q == '0))
    else $error("tsk_back: row not closed after final result");
`endif

endmodule

// ----- rtl/core/streaming_top_k_selector.sv -----
// ----------------------------------------------------------------------------
// Streaming top-k selector
// Keeps the k largest keys of each row and emits them in descending order.
// ----------------------------------------------------------------------------
// Keys enter one beat per cycle unless the input is held back; each one is
// numbered by its row position and inserted into a sorted array of K_MAX
// entries in one step, since every kept entry compares against the new key
// in parallel and shifts in the same cycle. After the beat marked tlast is
// inserted, the block sends exactly k result beats, one per cycle when the
// sink is ready, through an output register; while the results drain, the
// two-entry input queue fills and then holds the input back. Padding slots
// carry value 0 and position -1. k_count is to be written by the user on the
// configuration channel between beats; the block itself does not enforce
// this. 0 acts as 1 and values above K_MAX act as K_MAX.
// ----------------------------------------------------------------------------
module streaming_top_k_selector #(
  parameter int unsigned K_MAX = tsk_pkg::KMaxDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write channel: k_count.
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tsk_pkg::KCountW-1:0] cfg_data_i,
  // Input stream.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,  // [31:0] key_value
  input  logic                        s_axis_tlast,  // row_end
  // Result stream.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [55:0]                 m_axis_tdata,  // [31:0] out_value, [48:32] out_position
  output logic                        m_axis_tlast   // out_last
);

  logic [tsk_pkg::KCountW-1:0]        k_count_q, k_count_d;
  logic                               push_valid, push_ready;
  tsk_pkg::tsk_item_t                 push_item;
  logic                               pop_valid, pop_ready;
  tsk_pkg::tsk_item_t                 pop_item;
  logic signed [tsk_pkg::KeyW-1:0]    out_value;
  logic signed [tsk_pkg::OutPosW-1:0] out_position;

  // Configuration register.
  assign cfg_ready_o = 1'b1;
  assign k_count_d   = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : k_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_count_q <= tsk_pkg::KCountW'(1);
    end else begin
      k_count_q <= k_count_d;
    end
  end

  // Front end: numbers the keys.
  tsk_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_key_i     (signed'(s_axis_tdata)),
    .in_last_i    (s_axis_tlast),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  // Queue between front and back.
  tsk_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // Back end: insertion array and result sequencer.
  tsk_back #(
    .K_MAX (K_MAX)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .k_count_i      (k_count_q),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_item_i     (pop_item),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_value_o    (out_value),
    .out_position_o (out_position),
    .out_last_o     (m_axis_tlast)
  );

  // Result beat packing, zero filled to whole bytes.
  assign m_axis_tdata = {7'b0, out_position, out_value};

endmodule
